[rtl/tsta_pkg.sv]
`default_nettype none
package tsta_pkg;

    // reflected crc-32 polynomial and start value
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // trailer version byte
    localparam logic [7:0] TRAILER_VERSION = 8'd1;

    // trailer positions: crc bytes first, then the fixed twelve bytes
    localparam logic [3:0] TRL_FIRST_FIXED = 4'd4;
    localparam logic [3:0] TRL_FINAL       = 4'd15;

    // saturation point of the tail byte count
    localparam logic [2:0] TAIL_FULL = 3'd4;

    // fcs handling modes
    typedef enum logic [1:0] {
        FCS_ABSENT  = 2'd0,
        FCS_PRESENT = 2'd1,
        FCS_DETECT  = 2'd2,
        FCS_UNUSED  = 2'd3
    } t_fcs_mode;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FCS_MODE  = 2'd0,
        CFG_DEVICE_ID = 2'd1,
        CFG_PORT      = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_index;

    // one byte through the reflected crc register, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/timestamp_trailer_append.sv]
`default_nettype none
// Passes packet bytes through unchanged at one byte per cycle and, after each
// packet's last byte, appends a trailer: the CRC-32 of the packet (LSB first,
// plus one when crc_error is set, only when no FCS is taken to be present),
// then seconds and nanoseconds big-endian, version 1, device id big-endian
// and the port byte; out_last marks the final trailer byte. Bytes pass
// through an input register and then an output register. The input stalls
// while the trailer leaves the output register (the twelve fixed bytes if an
// FCS is present, all sixteen if not), and whenever the output side stalls.
// In detect mode the first packet to end decides FCS presence for good.
// Configuration writes are always ready and take effect the next cycle.
module timestamp_trailer_append (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // byte input
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_in_last,
    input  wire  [31:0] i_ts_seconds,
    input  wire  [29:0] i_ts_nanoseconds,
    input  wire         i_crc_error,
    // byte output
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    import tsta_pkg::*;

    // configuration registers
    t_fcs_mode   r_fcs_mode;
    logic [15:0] r_device_id;
    logic [7:0]  r_port_number;

    // input register
    logic        r_a_valid;
    logic [7:0]  r_a_byte;
    logic        r_a_last;
    logic [31:0] r_a_sec;
    logic [29:0] r_a_nsec;
    logic        r_a_err;

    // per-packet crc state
    logic [31:0] r_crc_running;
    logic [31:0] r_crc_lagged;
    logic [31:0] r_tail_bytes;
    logic [2:0]  r_bytes_seen;
    logic        r_fcs_decided;
    logic        r_fcs_found;

    // trailer sequencer
    logic        r_trl_active;
    logic [3:0]  r_trl_idx;
    logic [31:0] r_trl_crc;
    logic [31:0] r_trl_sec;
    logic [29:0] r_trl_nsec;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        out_free;
    logic        a_adv;
    logic        in_take;
    logic [31:0] n_crc_running;
    logic [31:0] n_crc_lagged;
    logic [31:0] n_tail_bytes;
    logic [2:0]  n_bytes_seen;
    logic        detect_hit;
    logic        n_fcs_found;
    logic        pkt_has_fcs;
    logic [31:0] crc_final;
    logic [7:0]  trl_byte;

    // handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign a_adv       = r_a_valid && out_free && !r_trl_active;
    assign o_in_stall  = r_a_valid && !a_adv;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    // crc and tail update for the byte leaving the input register
    always_comb begin
        n_crc_running = crc_byte(r_crc_running, r_a_byte);
        n_crc_lagged  = (r_bytes_seen >= TAIL_FULL)
                        ? crc_byte(r_crc_lagged, r_tail_bytes[7:0]) : r_crc_lagged;
        n_tail_bytes  = {r_a_byte, r_tail_bytes[31:8]};
        n_bytes_seen  = (r_bytes_seen < TAIL_FULL) ? r_bytes_seen + 3'd1 : r_bytes_seen;
        detect_hit    = !r_a_err && (n_bytes_seen >= TAIL_FULL)
                        && ((~n_crc_lagged) == n_tail_bytes);
        n_fcs_found   = r_fcs_decided ? r_fcs_found : detect_hit;
        case (r_fcs_mode)
            FCS_ABSENT:  pkt_has_fcs = 1'b0;
            FCS_DETECT:  pkt_has_fcs = n_fcs_found;
            FCS_PRESENT: pkt_has_fcs = 1'b1;
            default:     pkt_has_fcs = 1'b1;
        endcase
        crc_final = (~n_crc_running) + {31'd0, r_a_err};
    end

    // trailer byte select
    always_comb begin
        case (r_trl_idx)
            4'd0:    trl_byte = r_trl_crc[7:0];
            4'd1:    trl_byte = r_trl_crc[15:8];
            4'd2:    trl_byte = r_trl_crc[23:16];
            4'd3:    trl_byte = r_trl_crc[31:24];
            4'd4:    trl_byte = r_trl_sec[31:24];
            4'd5:    trl_byte = r_trl_sec[23:16];
            4'd6:    trl_byte = r_trl_sec[15:8];
            4'd7:    trl_byte = r_trl_sec[7:0];
            4'd8:    trl_byte = {2'd0, r_trl_nsec[29:24]};
            4'd9:    trl_byte = r_trl_nsec[23:16];
            4'd10:   trl_byte = r_trl_nsec[15:8];
            4'd11:   trl_byte = r_trl_nsec[7:0];
            4'd12:   trl_byte = TRAILER_VERSION;
            4'd13:   trl_byte = r_device_id[15:8];
            4'd14:   trl_byte = r_device_id[7:0];
            default: trl_byte = r_port_number;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcs_mode    <= FCS_DETECT;
            r_device_id   <= 16'd0;
            r_port_number <= 8'd0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FCS_MODE:  r_fcs_mode    <= t_fcs_mode'(i_cfg_data[1:0]);
                CFG_DEVICE_ID: r_device_id   <= i_cfg_data;
                CFG_PORT:      r_port_number <= i_cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
        if (in_take) begin
            r_a_byte <= i_data_byte;
            r_a_last <= i_in_last;
            r_a_sec  <= i_ts_seconds;
            r_a_nsec <= i_ts_nanoseconds;
            r_a_err  <= i_crc_error;
        end
    end

    // crc state, cleared after each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_running <= CRC_INIT;
            r_crc_lagged  <= CRC_INIT;
            r_tail_bytes  <= 32'd0;
            r_bytes_seen  <= 3'd0;
            r_fcs_decided <= 1'b0;
            r_fcs_found   <= 1'b0;
        end else if (a_adv) begin
            if (r_a_last) begin
                r_crc_running <= CRC_INIT;
                r_crc_lagged  <= CRC_INIT;
                r_tail_bytes  <= 32'd0;
                r_bytes_seen  <= 3'd0;
                if (r_fcs_mode == FCS_DETECT) begin
                    r_fcs_decided <= 1'b1;
                    r_fcs_found   <= n_fcs_found;
                end
            end else begin
                r_crc_running <= n_crc_running;
                r_crc_lagged  <= n_crc_lagged;
                r_tail_bytes  <= n_tail_bytes;
                r_bytes_seen  <= n_bytes_seen;
            end
        end
    end

    // output register and trailer sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_trl_active <= 1'b0;
            r_trl_idx    <= 4'd0;
        end else if (r_trl_active && out_free) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= trl_byte;
            r_out_last  <= (r_trl_idx == TRL_FINAL);
            r_trl_idx   <= r_trl_idx + 4'd1;
            if (r_trl_idx == TRL_FINAL) begin
                r_trl_active <= 1'b0;
            end
        end else if (a_adv) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= r_a_byte;
            r_out_last  <= 1'b0;
            if (r_a_last) begin
                r_trl_active <= 1'b1;
                r_trl_idx    <= pkt_has_fcs ? TRL_FIRST_FIXED : 4'd0;
            end
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    // trailer fields captured with the last byte
    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_last) begin
            r_trl_crc  <= crc_final;
            r_trl_sec  <= r_a_sec;
            r_trl_nsec <= r_a_nsec;
        end
    end

endmodule
`default_nettype wire
